// ----- src/kmd_pkg.sv -----
// Shared types and constants for the key matrix debounce block.
package kmd_pkg;

  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int GEOM_W      = 4;
  localparam int LIMIT_W     = 8;
  localparam int KEY_IDX_W   = 6;
  localparam int TOTAL_W     = 32;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int MUL_W       = 8;

  localparam int DEF_MAX_ROWS    = 8;
  localparam int DEF_MAX_COLUMNS = 8;

  localparam logic [GEOM_W-1:0]  RESET_ROWS    = 4'd8;
  localparam logic [GEOM_W-1:0]  RESET_COLUMNS = 4'd8;
  localparam logic [LIMIT_W-1:0] RESET_LIMIT   = 8'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_COUNT      = 2'd0,
    REG_COLUMN_COUNT   = 2'd1,
    REG_DEBOUNCE_LIMIT = 2'd2
  } kmd_reg_t;

  // Effective geometry (already clamped) and the debounce limit.
  typedef struct packed {
    logic [GEOM_W-1:0]  rows;
    logic [GEOM_W-1:0]  cols;
    logic [LIMIT_W-1:0] limit;
  } kmd_cfg_t;

  // One key's stored state.
  typedef struct packed {
    logic [TOTAL_W-1:0] rel_cnt;
    logic [TOTAL_W-1:0] prs_cnt;
    logic               pressed;
    logic [LIMIT_W-1:0] integ;
  } kmd_entry_t;

endpackage

// ----- src/kmd_cfg.sv -----
// Configuration registers and clamping of the matrix geometry.
module kmd_cfg #(
  parameter int MAX_ROWS    = kmd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = kmd_pkg::DEF_MAX_COLUMNS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [kmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output kmd_pkg::kmd_cfg_t                  cfg
);

  logic [kmd_pkg::GEOM_W-1:0]  row_count_r;
  logic [kmd_pkg::GEOM_W-1:0]  column_count_r;
  logic [kmd_pkg::LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= kmd_pkg::RESET_ROWS;
      column_count_r <= kmd_pkg::RESET_COLUMNS;
      limit_r        <= kmd_pkg::RESET_LIMIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        kmd_pkg::REG_ROW_COUNT: begin
          row_count_r <= cfg_data[kmd_pkg::GEOM_W-1:0];
        end
        kmd_pkg::REG_COLUMN_COUNT: begin
          column_count_r <= cfg_data[kmd_pkg::GEOM_W-1:0];
        end
        kmd_pkg::REG_DEBOUNCE_LIMIT: begin
          limit_r <= cfg_data[kmd_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Counts above the built-in matrix size fall back to the maximum.
  always_comb begin
    cfg.rows  = ({1'b0, row_count_r} > (kmd_pkg::GEOM_W+1)'(MAX_ROWS)) ?
                kmd_pkg::GEOM_W'(MAX_ROWS) : row_count_r;
    cfg.cols  = ({1'b0, column_count_r} > (kmd_pkg::GEOM_W+1)'(MAX_COLUMNS)) ?
                kmd_pkg::GEOM_W'(MAX_COLUMNS) : column_count_r;
    cfg.limit = limit_r;
  end

endmodule

// ----- src/kmd_decode.sv -----
// Maps a row and column onto a key index and checks them against the geometry.
module kmd_decode #(
  parameter int IDX_W = 6
) (
  input  kmd_pkg::kmd_cfg_t           cfg,
  input  logic [kmd_pkg::ROW_W-1:0]   row,
  input  logic [kmd_pkg::COL_W-1:0]   column,
  output logic [IDX_W-1:0]            key_idx,
  output logic                        key_valid
);

  logic [kmd_pkg::MUL_W-1:0] idx_full;

  always_comb begin
    idx_full  = kmd_pkg::MUL_W'(row) +
                kmd_pkg::MUL_W'(column) * kmd_pkg::MUL_W'(cfg.rows);
    key_idx   = idx_full[IDX_W-1:0];
    key_valid = (kmd_pkg::GEOM_W'(row) < cfg.rows) &&
                (kmd_pkg::GEOM_W'(column) < cfg.cols);
  end

endmodule

// ----- src/kmd_store.sv -----
// Per-key state memory with reset valid bits and write-to-read forwarding.
module kmd_store #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  kmd_pkg::kmd_entry_t wr_data,
  output kmd_pkg::kmd_entry_t rd_entry
);

  kmd_pkg::kmd_entry_t mem [DEPTH];
  logic [DEPTH-1:0]    vld_r;
  kmd_pkg::kmd_entry_t rd_data_r;
  logic                rd_vld_r;
  logic                fwd_hit_r;
  kmd_pkg::kmd_entry_t fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // The read sees the memory before this edge's write, so a write to the
  // same key at the same edge is captured separately and wins.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[rd_idx];
      rd_vld_r   <= vld_r[rd_idx];
      fwd_hit_r  <= wr_en && (wr_idx == rd_idx);
      fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      rd_entry = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_entry = rd_data_r;
    end else begin
      rd_entry = '0;
    end
  end

endmodule

// ----- src/kmd_update.sv -----
// Integrator step, hysteresis and press/release counting for one key.
module kmd_update (
  input  kmd_pkg::kmd_entry_t            entry_in,
  input  logic                           level,
  input  logic [kmd_pkg::LIMIT_W-1:0]    limit,
  output kmd_pkg::kmd_entry_t            entry_out,
  output logic                           pressed_now,
  output logic                           released_now
);

  logic [kmd_pkg::LIMIT_W-1:0] acc;

  always_comb begin
    acc = entry_in.integ;
    if (level) begin
      if (acc < limit) begin
        acc = acc + 1'b1;
      end
    end else if (acc != '0) begin
      acc = acc - 1'b1;
    end

    entry_out       = entry_in;
    entry_out.integ = acc;
    pressed_now     = 1'b0;
    released_now    = 1'b0;

    if (acc >= limit) begin
      pressed_now       = !entry_in.pressed;
      entry_out.pressed = 1'b1;
      entry_out.prs_cnt = entry_in.prs_cnt + kmd_pkg::TOTAL_W'(pressed_now);
    end else if (acc == '0) begin
      released_now      = entry_in.pressed;
      entry_out.pressed = 1'b0;
      entry_out.rel_cnt = entry_in.rel_cnt + kmd_pkg::TOTAL_W'(released_now);
    end
  end

endmodule

// ----- src/key_matrix_debounce.sv -----
// Top level of the keypad matrix integrating debounce block.
//
//  Channel   Direction  Handshake                    Payload
//  in_       input      in_valid / in_stall          in_row, in_column, in_level
//  out_      output     out_valid / out_stall        key_index, key_valid, status, totals
//  cfg_      input      cfg_wr_en, cfg_index         cfg_data
//
// One item is accepted every cycle while in_stall is low; the item and its key store
// read are registered in the update stage, and its result then in the output register.
// Reset clears the configuration to an 8 by 8 matrix with a limit of 10 and
// clears every key's valid bit at once, so items are taken straight after reset.
// A stalled output holds the result register; the item in the update stage then
// waits and in_stall rises, while a result can wait as a new item is accepted.
module key_matrix_debounce #(
  parameter int MAX_ROWS    = kmd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = kmd_pkg::DEF_MAX_COLUMNS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [kmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kmd_pkg::ROW_W-1:0]        in_row,
  input  logic [kmd_pkg::COL_W-1:0]        in_column,
  input  logic                             in_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kmd_pkg::KEY_IDX_W-1:0]    out_key_index,
  output logic                             out_key_valid,
  output logic                             out_key_down,
  output logic                             out_pressed_now,
  output logic                             out_released_now,
  output logic [kmd_pkg::TOTAL_W-1:0]      out_press_total,
  output logic [kmd_pkg::TOTAL_W-1:0]      out_release_total
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  kmd_pkg::kmd_cfg_t   cfg;
  logic [IDX_W-1:0]    dec_idx;
  logic                dec_valid;
  logic                in_accept;
  logic                s1_adv;
  logic                wr_en;
  kmd_pkg::kmd_entry_t cur_entry;
  kmd_pkg::kmd_entry_t new_entry;
  logic                upd_pnow;
  logic                upd_rnow;

  logic                s1_vld_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic                s1_key_valid_r;
  logic                s1_level_r;

  logic                              out_valid_r;
  logic [kmd_pkg::KEY_IDX_W-1:0]     out_key_index_r;
  logic                              out_key_valid_r;
  logic                              out_key_down_r;
  logic                              out_pressed_now_r;
  logic                              out_released_now_r;
  logic [kmd_pkg::TOTAL_W-1:0]       out_press_total_r;
  logic [kmd_pkg::TOTAL_W-1:0]       out_release_total_r;

  kmd_cfg #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kmd_decode #(
    .IDX_W (IDX_W)
  ) u_decode (
    .cfg       (cfg),
    .row       (in_row),
    .column    (in_column),
    .key_idx   (dec_idx),
    .key_valid (dec_valid)
  );

  assign s1_adv    = s1_vld_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_vld_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign wr_en     = s1_adv && s1_key_valid_r;

  kmd_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_idx   (dec_idx),
    .wr_en    (wr_en),
    .wr_idx   (s1_idx_r),
    .wr_data  (new_entry),
    .rd_entry (cur_entry)
  );

  kmd_update u_update (
    .entry_in     (cur_entry),
    .level        (s1_level_r),
    .limit        (cfg.limit),
    .entry_out    (new_entry),
    .pressed_now  (upd_pnow),
    .released_now (upd_rnow)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_accept) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_idx_r       <= dec_idx;
      s1_key_valid_r <= dec_valid;
      s1_level_r     <= in_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // An item outside the configured matrix reports all zero fields.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_key_valid_r) begin
        out_key_index_r     <= kmd_pkg::KEY_IDX_W'(s1_idx_r);
        out_key_valid_r     <= 1'b1;
        out_key_down_r      <= new_entry.pressed;
        out_pressed_now_r   <= upd_pnow;
        out_released_now_r  <= upd_rnow;
        out_press_total_r   <= new_entry.prs_cnt;
        out_release_total_r <= new_entry.rel_cnt;
      end else begin
        out_key_index_r     <= '0;
        out_key_valid_r     <= 1'b0;
        out_key_down_r      <= 1'b0;
        out_pressed_now_r   <= 1'b0;
        out_released_now_r  <= 1'b0;
        out_press_total_r   <= '0;
        out_release_total_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_index     = out_key_index_r;
  assign out_key_valid     = out_key_valid_r;
  assign out_key_down      = out_key_down_r;
  assign out_pressed_now   = out_pressed_now_r;
  assign out_released_now  = out_released_now_r;
  assign out_press_total   = out_press_total_r;
  assign out_release_total = out_release_total_r;

  a_store_write_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> s1_vld_r && s1_key_valid_r && (!out_valid_r || !out_stall))
    else $error("store written without a valid item leaving the update stage");

  a_press_release_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_pressed_now_r && out_released_now_r))
    else $error("press and release reported on the same item");

  a_flags_match_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_pressed_now_r || out_released_now_r)
      |-> (out_key_down_r == out_pressed_now_r))
    else $error("press or release flag disagrees with the debounced state");

  a_invalid_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_key_valid_r
      |-> !out_key_down_r && (out_press_total_r == '0) && (out_release_total_r == '0))
    else $error("result for a key outside the matrix carries key state");

  a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !in_accept |=> !s1_vld_r)
    else $error("update stage kept an item it had passed on");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the key matrix debounce block: directed cases, random scans.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS    = kmd_pkg::DEF_MAX_ROWS;
  localparam int MAX_COLUMNS = kmd_pkg::DEF_MAX_COLUMNS;
  localparam int KEY_DEPTH   = MAX_ROWS * MAX_COLUMNS;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [kmd_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [kmd_pkg::KEY_IDX_W-1:0] key_index;
    logic                          key_valid;
    logic                          key_down;
    logic                          pressed_now;
    logic                          released_now;
    logic [kmd_pkg::TOTAL_W-1:0]   press_total;
    logic [kmd_pkg::TOTAL_W-1:0]   release_total;
  } key_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [kmd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [kmd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [kmd_pkg::ROW_W-1:0]       in_row = '0;
  logic [kmd_pkg::COL_W-1:0]       in_column = '0;
  logic                            in_level = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [kmd_pkg::KEY_IDX_W-1:0]   out_key_index;
  logic                            out_key_valid;
  logic                            out_key_down;
  logic                            out_pressed_now;
  logic                            out_released_now;
  logic [kmd_pkg::TOTAL_W-1:0]     out_press_total;
  logic [kmd_pkg::TOTAL_W-1:0]     out_release_total;

  key_matrix_debounce #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row           (in_row),
    .in_column        (in_column),
    .in_level         (in_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_index    (out_key_index),
    .out_key_valid    (out_key_valid),
    .out_key_down     (out_key_down),
    .out_pressed_now  (out_pressed_now),
    .out_released_now (out_released_now),
    .out_press_total  (out_press_total),
    .out_release_total(out_release_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the configuration and of every key's state.
  logic [kmd_pkg::GEOM_W-1:0]  cfg_rows  = kmd_pkg::RESET_ROWS;
  logic [kmd_pkg::GEOM_W-1:0]  cfg_cols  = kmd_pkg::RESET_COLUMNS;
  logic [kmd_pkg::LIMIT_W-1:0] cfg_limit = kmd_pkg::RESET_LIMIT;
  logic [kmd_pkg::LIMIT_W-1:0] key_integ    [KEY_DEPTH];
  logic                        key_pressed  [KEY_DEPTH];
  logic [kmd_pkg::TOTAL_W-1:0] key_presses  [KEY_DEPTH];
  logic [kmd_pkg::TOTAL_W-1:0] key_releases [KEY_DEPTH];

  key_result_t expected_keys[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_on = 1'b0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  settings_used = 0;
  int  mismatches = 0;

  function automatic int eff_rows();
    return (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
  endfunction

  function automatic int eff_cols();
    return (cfg_cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(cfg_cols);
  endfunction

  // Integrating debounce of one sample, updating the predicted key store.
  function automatic key_result_t predict_key(logic [kmd_pkg::ROW_W-1:0] row,
                                              logic [kmd_pkg::COL_W-1:0] column,
                                              logic level);
    key_result_t res;
    int rows_eff;
    int cols_eff;
    int idx;
    int acc;
    res = '0;
    rows_eff = eff_rows();
    cols_eff = eff_cols();
    if (row >= rows_eff || column >= cols_eff) return res;
    idx = row + column * rows_eff;
    acc = key_integ[idx];
    if (level) begin
      if (acc < cfg_limit) acc++;
    end else if (acc > 0) begin
      acc--;
    end
    key_integ[idx] = 8'(acc);
    if (acc >= cfg_limit) begin
      if (!key_pressed[idx]) begin
        key_presses[idx] = key_presses[idx] + 1;
        res.pressed_now = 1'b1;
      end
      key_pressed[idx] = 1'b1;
    end else if (acc == 0) begin
      if (key_pressed[idx]) begin
        key_releases[idx] = key_releases[idx] + 1;
        res.released_now = 1'b1;
      end
      key_pressed[idx] = 1'b0;
    end
    res.key_index     = 6'(idx);
    res.key_valid     = 1'b1;
    res.key_down      = key_pressed[idx];
    res.press_total   = key_presses[idx];
    res.release_total = key_releases[idx];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 20)
      $display("mismatch at result %0d: %s got %0h, expected %0h", results_checked, what, got,
               want);
    mismatches++;
  endtask

  task automatic check_result();
    key_result_t want;
    if (expected_keys.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(out_key_index), 0);
      return;
    end
    want = expected_keys.pop_front();
    if (out_key_index !== want.key_index)
      report_mismatch("key_index", 32'(out_key_index), 32'(want.key_index));
    if (out_key_valid !== want.key_valid)
      report_mismatch("key_valid", 32'(out_key_valid), 32'(want.key_valid));
    if (out_key_down !== want.key_down)
      report_mismatch("key_down", 32'(out_key_down), 32'(want.key_down));
    if (out_pressed_now !== want.pressed_now)
      report_mismatch("pressed_now", 32'(out_pressed_now), 32'(want.pressed_now));
    if (out_released_now !== want.released_now)
      report_mismatch("released_now", 32'(out_released_now), 32'(want.released_now));
    if (out_press_total !== want.press_total)
      report_mismatch("press_total", out_press_total, want.press_total);
    if (out_release_total !== want.release_total)
      report_mismatch("release_total", out_release_total, want.release_total);
    results_checked++;
  endtask

  // Result side: check what is taken at this edge, then choose the stall for the next one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(logic [kmd_pkg::ROW_W-1:0] row, logic [kmd_pkg::COL_W-1:0] column,
                           logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_row    <= row;
    in_column <= column;
    in_level  <= level;
    do @(posedge clk); while (in_stall);
    expected_keys.push_back(predict_key(row, column, level));
    items_sent++;
  endtask

  // Drops the input and waits until every pending result has been taken.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_keys.size() != 0);
  endtask

  task automatic write_reg(logic [kmd_pkg::CFG_INDEX_W-1:0] idx,
                           logic [kmd_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      kmd_pkg::REG_ROW_COUNT:      cfg_rows  = data[kmd_pkg::GEOM_W-1:0];
      kmd_pkg::REG_COLUMN_COUNT:   cfg_cols  = data[kmd_pkg::GEOM_W-1:0];
      kmd_pkg::REG_DEBOUNCE_LIMIT: cfg_limit = data;
      default: ;
    endcase
  endtask

  // Upper data bits of the geometry registers are ignored, so they carry noise.
  task automatic configure(logic [kmd_pkg::GEOM_W-1:0] rows, logic [kmd_pkg::GEOM_W-1:0] cols,
                           logic [kmd_pkg::LIMIT_W-1:0] limit);
    write_reg(kmd_pkg::REG_ROW_COUNT, {4'($urandom), rows});
    write_reg(kmd_pkg::REG_COLUMN_COUNT, {4'($urandom), cols});
    write_reg(kmd_pkg::REG_DEBOUNCE_LIMIT, limit);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [kmd_pkg::GEOM_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return 4'($urandom_range(15, MAX_ROWS + 1));
    return 4'($urandom_range(MAX_ROWS, 1));
  endfunction

  function automatic logic [kmd_pkg::LIMIT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 70) return 8'($urandom_range(4, 1));
    return 8'($urandom_range(12, 5));
  endfunction

  // Mostly press and release runs on one key, with contact bounce for limits below 16, plus stray samples.
  task automatic run_segment(int count);
    int start;
    int rows_eff;
    int cols_eff;
    int run_len;
    int k;
    int bounce;
    logic [kmd_pkg::ROW_W-1:0] r;
    logic [kmd_pkg::COL_W-1:0] c;
    start = items_sent;
    rows_eff = eff_rows();
    cols_eff = eff_cols();
    bounce = (cfg_limit < 16) ? 10 : 0;
    while (items_sent - start < count) begin
      if ($urandom_range(99) < 75 && rows_eff > 0 && cols_eff > 0) begin
        r = 3'($urandom_range(rows_eff - 1, 0));
        c = 3'($urandom_range(cols_eff - 1, 0));
        run_len = (cfg_limit < 16) ? $urandom_range(int'(cfg_limit) + 3, 1)
                                   : int'(cfg_limit) + $urandom_range(8, 0);
        for (k = 0; k < run_len; k++)
          send_item(r, c, !(bounce != 0 && $urandom_range(bounce - 1, 0) == 0));
        run_len = (cfg_limit < 16) ? $urandom_range(int'(cfg_limit) + 3, 1)
                                   : int'(cfg_limit) + $urandom_range(8, 0);
        for (k = 0; k < run_len; k++)
          send_item(r, c, bounce != 0 && $urandom_range(bounce - 1, 0) == 0);
      end else begin
        send_item(3'($urandom), 3'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_press_release();
    // One sample under the reset configuration first.
    send_item(3'd3, 3'd4, 1'b1);
    wait_drain();
    configure(4'd8, 4'd8, 8'd2);
    send_item(3'd0, 3'd0, 1'b1);
    send_item(3'd0, 3'd0, 1'b1);
    send_item(3'd0, 3'd0, 1'b0);
    send_item(3'd0, 3'd0, 1'b0);
    send_item(3'd7, 3'd7, 1'b1);
    send_item(3'd7, 3'd7, 1'b1);
    send_item(3'd0, 3'd1, 1'b1);
    send_item(3'd0, 3'd1, 1'b1);
    wait_drain();
  endtask

  task automatic test_geometry();
    write_reg(REG_SPARE, 8'($urandom));
    // Oversized counts clamp to the full matrix, so the corner key is still entry 63.
    configure(4'd15, 4'd15, 8'd1);
    send_item(3'd7, 3'd7, 1'b0);
    send_item(3'd7, 3'd7, 1'b0);
    wait_drain();
    configure(4'd3, 4'd0, 8'd1);
    send_item(3'd0, 3'd0, 1'b1);
    wait_drain();
    // A smaller geometry maps (2,2) onto the entry pressed earlier as (0,1).
    configure(4'd3, 4'd3, 8'd2);
    send_item(3'd3, 3'd0, 1'b1);
    send_item(3'd0, 3'd3, 1'b1);
    send_item(3'd2, 3'd2, 1'b0);
    wait_drain();
  endtask

  task automatic test_limit_edges();
    configure(4'd8, 4'd1, 8'd0);
    send_item(3'd5, 3'd0, 1'b1);
    send_item(3'd5, 3'd0, 1'b0);
    wait_drain();
    configure(4'd8, 4'd8, 8'd5);
    repeat (5) send_item(3'd1, 3'd0, 1'b1);
    wait_drain();
    // Lowered limit: the integrator sits above it, holds on high samples and counts down on low ones.
    configure(4'd8, 4'd8, 8'd2);
    send_item(3'd1, 3'd0, 1'b1);
    send_item(3'd1, 3'd0, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int phase;
    int seg;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct <= 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct <= 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (seg = 0; seg < 12; seg++) begin
        if (phase == 2 && seg == 0)
          configure(4'($urandom_range(MAX_ROWS, 1)), 4'($urandom_range(MAX_COLUMNS, 1)),
                    8'd255);
        else
          configure(pick_count(), pick_count(), pick_limit());
        run_segment(40);
        wait_drain();
      end
    end
  endtask

  task automatic test_backpressure();
    int k;
    configure(4'd8, 4'd8, 8'd3);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (80) @(posedge clk);
        hold_on <= 1'b0;
      end
      for (k = 0; k < 40; k++) send_item(3'($urandom), 3'($urandom), 1'($urandom));
    join
    wait_drain();
  endtask

  initial begin
    for (int k = 0; k < KEY_DEPTH; k++) begin
      key_integ[k]    = '0;
      key_pressed[k]  = 1'b0;
      key_presses[k]  = '0;
      key_releases[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_press_release();
    test_geometry();
    test_limit_edges();
    test_random_traffic();
    test_backpressure();
    wait_drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d key samples, checked %0d results across %0d register settings,",
             items_sent, results_checked, settings_used);
    $display("with idling on both sides, a long output hold-off and edge geometries and limits.");
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results still pending", expected_keys.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/kmd_pkg.sv
src/kmd_cfg.sv
src/kmd_decode.sv
src/kmd_store.sv
src/kmd_update.sv
src/key_matrix_debounce.sv
sim/testbench.sv
